[sv/mbrtu_pkg.sv]
// ----------------------------------------------------------------------------
// mbrtu_pkg: shared types and constants of the RTU slave frame engine
// Table and frame sizes, event and function codes, controller/datapath
// command and status bundles, and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int FRAME_BYTES = 256;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int BUF_AW      = $clog2(FRAME_BYTES);
    localparam int CNT_W       = BUF_AW + 1;
    localparam int SUM_W       = 17;
    localparam int WI_W        = 11;
    localparam int OFF_W       = CNT_W + 3;

    // input event codes
    localparam logic [2:0] OP_RX        = 3'd0;
    localparam logic [2:0] OP_TX        = 3'd1;
    localparam logic [2:0] OP_SET_INPUT = 3'd2;
    localparam logic [2:0] OP_SET_DISC  = 3'd3;
    localparam logic [2:0] OP_SET_HOLD  = 3'd4;
    localparam logic [2:0] OP_SET_COIL  = 3'd5;

    // engine modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_TX   = 2'd2;

    // frame status codes
    localparam logic [1:0] FST_NONE = 2'd0;
    localparam logic [1:0] FST_OK   = 2'd1;
    localparam logic [1:0] FST_CRC  = 2'd2;
    localparam logic [1:0] FST_BAD  = 2'd3;

    // function codes
    localparam logic [7:0] FC_RD_COILS = 8'd1;
    localparam logic [7:0] FC_RD_DISC  = 8'd2;
    localparam logic [7:0] FC_RD_HOLD  = 8'd3;
    localparam logic [7:0] FC_RD_INPUT = 8'd4;
    localparam logic [7:0] FC_WR_COIL  = 8'd5;
    localparam logic [7:0] FC_WR_REG   = 8'd6;
    localparam logic [7:0] FC_WR_COILS = 8'h0F;
    localparam logic [7:0] FC_WR_REGS  = 8'h10;

    // transmit byte kinds
    localparam logic [1:0] KIND_IMM  = 2'd0;
    localparam logic [1:0] KIND_BITS = 2'd1;
    localparam logic [1:0] KIND_REG  = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    localparam logic [15:0] MAX_RD_BITS  = 16'd2000;
    localparam logic [15:0] MAX_RD_REGS  = 16'd125;
    localparam logic [15:0] MAX_WR_BITS  = 16'd1968;
    localparam logic [15:0] MAX_WR_REGS  = 16'd123;

    typedef struct packed {
        logic latch;
        logic clr;
        logic rx;
        logic local_wr;
        logic tx_begin;
        logic tbl_rd;
        logic tbl_acc;
        logic walk_hi;
        logic walk_wr;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       out_busy;
        logic [2:0] opcode;
        logic       mode_tx;
        logic       rx_walk;
        logic [1:0] tx_kind;
        logic       tbl_more;
        logic       walk_fc16;
        logic       walk_last;
    } t_dp_sts;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[sv/modbus_rtu_slave_frame_engine_core.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_engine_core: byte-serial RTU slave frame engine
// Collects request bytes addressed to this slave, checks the CRC-16, runs
// read/write functions on the coil, discrete, holding and input tables, and
// hands out the response one byte per transmit slot.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata / tuser / tlast
//  s_axis    | in        | tuser: opcode; tdata: rx_byte, table_index, table_value
//  m_axis    | out       | tuser: tx_valid, frame_status; tdata: tx_byte; tlast: tx_last
//  cfg       | in        | i_cfg_we / i_cfg_wdata: slave address
//
// Sequencing: one event per transaction, processed to completion before the next.
//   Every event is latched and decoded, and ends in a result hand-off. A coil
//   or discrete read byte reads the table once per bit through the read port,
//   a register byte once. A frame ending in function 15 or 16 walks the request
//   buffer once per written entry, reading a high byte first for function 16.
// Reset: synchronous, active low; then a clearing pass zeroes the tables,
//   during which no event is taken (configuration writes are).
// Stalls: a result held in the output register blocks the next event.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_frame_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] rx_byte, [17:8] table_index, [33:18] table_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic [2:0]  m_axis_tuser,   // [0] tx_valid, [2:1] frame_status
    output logic        m_axis_tlast,   // tx_last
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    mbrtu_pkg::t_dp_cmd cmd;
    mbrtu_pkg::t_dp_sts sts;
    logic               tx_valid;
    logic [1:0]         frame_status;

    // sequencing: one event in flight
    mbrtu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // frame state, tables and result register
    mbrtu_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (s_axis_tuser),
        .i_rx_byte      (s_axis_tdata[7:0]),
        .i_table_index  (s_axis_tdata[17:8]),
        .i_table_value  (s_axis_tdata[33:18]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_tx_valid     (tx_valid),
        .o_tx_byte      (m_axis_tdata),
        .o_tx_last      (m_axis_tlast),
        .o_frame_status (frame_status)
    );

    assign m_axis_tuser = {frame_status, tx_valid};

endmodule

[sv/mbrtu_ram.sv]
// ----------------------------------------------------------------------------
// mbrtu_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mbrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/mbrtu_datapath.sv]
// ----------------------------------------------------------------------------
// mbrtu_datapath: frame registers, tables and response builder
// Holds the receive and transmit state, the request buffer, the four tables,
// and the result register; acts on commands from the controller.
// ----------------------------------------------------------------------------
module mbrtu_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbrtu_pkg::t_dp_cmd  i_cmd,
    output mbrtu_pkg::t_dp_sts  o_sts,
    input  logic [2:0]          i_opcode,
    input  logic [7:0]          i_rx_byte,
    input  logic [9:0]          i_table_index,
    input  logic [15:0]         i_table_value,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_tx_valid,
    output logic [7:0]          o_tx_byte,
    output logic                o_tx_last,
    output logic [1:0]          o_frame_status
);

    localparam int AW = mbrtu_pkg::TBL_AW;
    localparam int CW = mbrtu_pkg::CNT_W;
    localparam int SW = mbrtu_pkg::SUM_W;

    // latched item
    logic [2:0]  r_op;
    logic [7:0]  r_rx;
    logic [9:0]  r_idx;
    logic [15:0] r_val;

    logic [7:0]  r_slave_addr;
    logic [1:0]  r_mode;
    logic [CW-1:0] r_rcnt, r_exp, r_resp_len, r_tx_pos;
    logic [15:0] r_rcrc, r_tx_crc;
    logic [7:0]  r_addr_b, r_fc, r_bc, r_hi;
    logic [15:0] r_start, r_cnt;
    logic [AW-1:0] r_clr_addr;
    logic [mbrtu_pkg::WI_W-1:0] r_wi;

    logic        r_res_valid, r_res_last, r_crc_upd;
    logic [7:0]  r_res_byte;
    logic [1:0]  r_res_status;

    logic [SW-1:0] r_rd_base;
    logic [mbrtu_pkg::OFF_W-1:0] r_bit_off;
    logic [2:0]  r_j;
    logic        r_is_bits, r_q_odd, r_rd_ok;

    logic        r_out_valid, r_out_tx_valid, r_out_last;
    logic [7:0]  r_out_byte;
    logic [1:0]  r_out_status;

    // receive decode
    logic [15:0] rx_crc;
    logic [CW-1:0] rx_cnt, rx_exp;
    logic        rx_kill, rx_done, rx_match, rx_go;
    logic [1:0]  rx_status;
    logic [SW-1:0] cnt17, bytes_bits, ex_len;
    logic        ex_ok, ex_walk, ex_coil, ex_hold;

    // transmit decode
    logic [CW+1:0] tx_p2, tx_len2;
    logic [CW-1:0] tx_q;
    logic        tx_data;
    logic [1:0]  tx_kind;
    logic [7:0]  tx_imm;
    logic [mbrtu_pkg::OFF_W-1:0] tx_off;

    // memories
    logic        coil_we, disc_we, hold_we, inp_we, buf_we;
    logic [AW-1:0] coil_wa, disc_wa, hold_wa, inp_wa, tbl_ra;
    logic        coil_wd, disc_wd, coil_rd, disc_rd;
    logic [15:0] hold_wd, inp_wd, hold_rd, inp_rd;
    logic [mbrtu_pkg::BUF_AW-1:0] buf_wa, buf_ra;
    logic [7:0]  buf_rd;

    logic [SW-1:0] start17, walk_addr, rd_addr, idx17;
    logic        start_ok, walk_ok, idx_ok, rd_in_range, rd_bit_ok;
    logic        tbl_bit;
    logic [15:0] tbl_reg;

    assign start17   = SW'(r_start);
    assign idx17     = SW'(r_idx);
    assign walk_addr = start17 + SW'(r_wi);
    assign rd_addr   = r_rd_base + SW'(r_j);
    assign start_ok  = start17 < SW'(mbrtu_pkg::TABLE_DEPTH);
    assign walk_ok   = walk_addr < SW'(mbrtu_pkg::TABLE_DEPTH);
    assign idx_ok    = idx17 < SW'(mbrtu_pkg::TABLE_DEPTH);
    assign rd_in_range = rd_addr < SW'(mbrtu_pkg::TABLE_DEPTH);
    assign rd_bit_ok = SW'(r_bit_off) + SW'(r_j) < SW'(r_cnt);
    assign tbl_ra    = rd_addr[AW-1:0];

    // ---- receive path ----
    always_comb begin
        rx_crc = mbrtu_pkg::crc_add((r_mode == mbrtu_pkg::MODE_IDLE) ?
                                    mbrtu_pkg::CRC_INIT : r_rcrc, r_rx);
        rx_cnt = r_rcnt + CW'(1);
        rx_exp = r_exp;
        rx_kill = 1'b0;
        if (rx_cnt == CW'(2)) begin
            rx_exp = (r_rx == mbrtu_pkg::FC_WR_COILS || r_rx == mbrtu_pkg::FC_WR_REGS) ?
                     '0 : CW'(8);
        end
        if (rx_cnt == CW'(7) && rx_exp == '0) begin
            if (CW'(9) + CW'(r_rx) > CW'(mbrtu_pkg::FRAME_BYTES)) begin
                rx_kill = 1'b1;
            end else begin
                rx_exp = CW'(9) + CW'(r_rx);
            end
        end
        rx_done = !rx_kill && rx_exp != '0 && rx_cnt >= rx_exp;

        cnt17      = SW'(r_cnt);
        bytes_bits = (cnt17 + SW'(7)) >> 3;
        ex_len  = '0;
        ex_walk = 1'b0;
        ex_coil = 1'b0;
        ex_hold = 1'b0;
        case (r_fc) inside
            mbrtu_pkg::FC_RD_COILS, mbrtu_pkg::FC_RD_DISC: begin
                if (r_cnt != '0 && r_cnt <= mbrtu_pkg::MAX_RD_BITS) begin
                    ex_len = SW'(5) + bytes_bits;
                end
            end
            mbrtu_pkg::FC_RD_HOLD, mbrtu_pkg::FC_RD_INPUT: begin
                if (r_cnt != '0 && r_cnt <= mbrtu_pkg::MAX_RD_REGS) begin
                    ex_len = SW'(5) + (cnt17 << 1);
                end
            end
            mbrtu_pkg::FC_WR_COIL: begin
                if (r_cnt == mbrtu_pkg::COIL_ON || r_cnt == mbrtu_pkg::COIL_OFF) begin
                    ex_len  = SW'(8);
                    ex_coil = 1'b1;
                end
            end
            mbrtu_pkg::FC_WR_REG: begin
                ex_len  = SW'(8);
                ex_hold = 1'b1;
            end
            mbrtu_pkg::FC_WR_COILS: begin
                if (r_cnt != '0 && r_cnt <= mbrtu_pkg::MAX_WR_BITS &&
                    SW'(r_bc) == bytes_bits) begin
                    ex_len  = SW'(8);
                    ex_walk = 1'b1;
                end
            end
            mbrtu_pkg::FC_WR_REGS: begin
                if (r_cnt != '0 && r_cnt <= mbrtu_pkg::MAX_WR_REGS &&
                    SW'(r_bc) == (cnt17 << 1)) begin
                    ex_len  = SW'(8);
                    ex_walk = 1'b1;
                end
            end
            default: ;
        endcase
        ex_ok = ex_len != '0 && ex_len <= SW'(mbrtu_pkg::FRAME_BYTES);

        rx_match = (r_mode == mbrtu_pkg::MODE_IDLE) && (r_rx == r_slave_addr);
        rx_go    = (r_mode == mbrtu_pkg::MODE_RX) && rx_done && rx_crc == '0 && ex_ok;
        rx_status = mbrtu_pkg::FST_NONE;
        if (r_mode == mbrtu_pkg::MODE_RX) begin
            if (rx_kill) begin
                rx_status = mbrtu_pkg::FST_BAD;
            end else if (rx_done) begin
                if (rx_crc != '0) begin
                    rx_status = mbrtu_pkg::FST_CRC;
                end else if (!ex_ok) begin
                    rx_status = mbrtu_pkg::FST_BAD;
                end else begin
                    rx_status = mbrtu_pkg::FST_OK;
                end
            end
        end
    end

    // ---- transmit decode ----
    always_comb begin
        tx_p2   = (CW+2)'(r_tx_pos) + (CW+2)'(2);
        tx_len2 = (CW+2)'(r_resp_len);
        tx_data = tx_p2 < tx_len2;
        tx_q    = r_tx_pos - CW'(3);
        tx_off  = mbrtu_pkg::OFF_W'(tx_q) << 3;
        tx_kind = mbrtu_pkg::KIND_IMM;
        tx_imm  = 8'h00;
        if (r_tx_pos == CW'(0)) begin
            tx_imm = r_addr_b;
        end else if (r_tx_pos == CW'(1)) begin
            tx_imm = r_fc;
        end else if (r_fc == mbrtu_pkg::FC_RD_COILS || r_fc == mbrtu_pkg::FC_RD_DISC) begin
            if (r_tx_pos == CW'(2)) begin
                tx_imm = bytes_bits[7:0];
            end else begin
                tx_kind = mbrtu_pkg::KIND_BITS;
            end
        end else if (r_fc == mbrtu_pkg::FC_RD_HOLD || r_fc == mbrtu_pkg::FC_RD_INPUT) begin
            if (r_tx_pos == CW'(2)) begin
                tx_imm = cnt17[6:0] << 1 == 8'h00 ? 8'h00 : {cnt17[6:0], 1'b0};
            end else begin
                tx_kind = mbrtu_pkg::KIND_REG;
            end
        end else begin
            case (r_tx_pos[2:0])
                3'd2:    tx_imm = r_start[15:8];
                3'd3:    tx_imm = r_start[7:0];
                3'd4:    tx_imm = r_cnt[15:8];
                3'd5:    tx_imm = r_cnt[7:0];
                default: tx_imm = 8'h00;
            endcase
        end
        if (!tx_data) begin
            tx_kind = mbrtu_pkg::KIND_IMM;
        end
    end

    // ---- table selection ----
    always_comb begin
        tbl_bit = 1'b0;
        tbl_reg = 16'h0000;
        case (r_fc)
            mbrtu_pkg::FC_RD_COILS: tbl_bit = coil_rd;
            mbrtu_pkg::FC_RD_DISC:  tbl_bit = disc_rd;
            mbrtu_pkg::FC_RD_HOLD:  tbl_reg = hold_rd;
            mbrtu_pkg::FC_RD_INPUT: tbl_reg = inp_rd;
            default: ;
        endcase
        if (!r_rd_ok) begin
            tbl_bit = 1'b0;
            tbl_reg = 16'h0000;
        end
    end

    // ---- memory write ports ----
    always_comb begin
        coil_we = 1'b0; coil_wa = r_clr_addr; coil_wd = 1'b0;
        disc_we = 1'b0; disc_wa = r_clr_addr; disc_wd = 1'b0;
        hold_we = 1'b0; hold_wa = r_clr_addr; hold_wd = 16'h0000;
        inp_we  = 1'b0; inp_wa  = r_clr_addr; inp_wd  = 16'h0000;
        if (i_cmd.clr) begin
            coil_we = 1'b1;
            disc_we = 1'b1;
            hold_we = 1'b1;
            inp_we  = 1'b1;
        end else if (i_cmd.rx && rx_go && start_ok) begin
            coil_we = ex_coil;
            coil_wa = start17[AW-1:0];
            coil_wd = (r_cnt == mbrtu_pkg::COIL_ON);
            hold_we = ex_hold;
            hold_wa = start17[AW-1:0];
            hold_wd = r_cnt;
        end else if (i_cmd.walk_wr && walk_ok) begin
            coil_we = (r_fc == mbrtu_pkg::FC_WR_COILS);
            coil_wa = walk_addr[AW-1:0];
            coil_wd = buf_rd[r_wi[2:0]];
            hold_we = (r_fc == mbrtu_pkg::FC_WR_REGS);
            hold_wa = walk_addr[AW-1:0];
            hold_wd = {r_hi, buf_rd};
        end else if (i_cmd.local_wr && idx_ok) begin
            coil_we = (r_op == mbrtu_pkg::OP_SET_COIL);
            coil_wa = idx17[AW-1:0];
            coil_wd = r_val[0];
            disc_we = (r_op == mbrtu_pkg::OP_SET_DISC);
            disc_wa = idx17[AW-1:0];
            disc_wd = r_val[0];
            hold_we = (r_op == mbrtu_pkg::OP_SET_HOLD);
            hold_wa = idx17[AW-1:0];
            hold_wd = r_val;
            inp_we  = (r_op == mbrtu_pkg::OP_SET_INPUT);
            inp_wa  = idx17[AW-1:0];
            inp_wd  = r_val;
        end

        buf_we = i_cmd.rx && (rx_match || (r_mode == mbrtu_pkg::MODE_RX &&
                 r_rcnt < CW'(mbrtu_pkg::FRAME_BYTES)));
        buf_wa = rx_match ? '0 : r_rcnt[mbrtu_pkg::BUF_AW-1:0];
        if (i_cmd.walk_hi) begin
            buf_ra = mbrtu_pkg::BUF_AW'(8 + 2 * int'(r_wi));
        end else if (r_fc == mbrtu_pkg::FC_WR_REGS) begin
            buf_ra = mbrtu_pkg::BUF_AW'(7 + 2 * int'(r_wi));
        end else begin
            buf_ra = mbrtu_pkg::BUF_AW'(7 + int'(r_wi >> 3));
        end
    end

    mbrtu_ram #(.WIDTH(8), .DEPTH(mbrtu_pkg::FRAME_BYTES)) u_buf (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(buf_wa), .i_wdata(r_rx),
        .i_raddr(buf_ra), .o_rdata(buf_rd));
    mbrtu_ram #(.WIDTH(1), .DEPTH(mbrtu_pkg::TABLE_DEPTH)) u_coil (
        .i_clk(i_clk), .i_we(coil_we), .i_waddr(coil_wa), .i_wdata(coil_wd),
        .i_raddr(tbl_ra), .o_rdata(coil_rd));
    mbrtu_ram #(.WIDTH(1), .DEPTH(mbrtu_pkg::TABLE_DEPTH)) u_disc (
        .i_clk(i_clk), .i_we(disc_we), .i_waddr(disc_wa), .i_wdata(disc_wd),
        .i_raddr(tbl_ra), .o_rdata(disc_rd));
    mbrtu_ram #(.WIDTH(16), .DEPTH(mbrtu_pkg::TABLE_DEPTH)) u_hold (
        .i_clk(i_clk), .i_we(hold_we), .i_waddr(hold_wa), .i_wdata(hold_wd),
        .i_raddr(tbl_ra), .o_rdata(hold_rd));
    mbrtu_ram #(.WIDTH(16), .DEPTH(mbrtu_pkg::TABLE_DEPTH)) u_inp (
        .i_clk(i_clk), .i_we(inp_we), .i_waddr(inp_wa), .i_wdata(inp_wd),
        .i_raddr(tbl_ra), .o_rdata(inp_rd));

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_opcode;
            r_rx  <= i_rx_byte;
            r_idx <= i_table_index;
            r_val <= i_table_value;
        end
        if (i_cmd.rx && r_mode == mbrtu_pkg::MODE_IDLE && rx_match) begin
            r_addr_b <= r_rx;
        end
        if (i_cmd.rx && r_mode == mbrtu_pkg::MODE_RX) begin
            case (r_rcnt)
                CW'(1):  r_fc           <= r_rx;
                CW'(2):  r_start[15:8]  <= r_rx;
                CW'(3):  r_start[7:0]   <= r_rx;
                CW'(4):  r_cnt[15:8]    <= r_rx;
                CW'(5):  r_cnt[7:0]     <= r_rx;
                CW'(6):  r_bc           <= r_rx;
                default: ;
            endcase
        end
        if (i_cmd.walk_hi) begin
            r_hi <= buf_rd;
        end
        if (i_cmd.tx_begin) begin
            r_is_bits <= (tx_kind == mbrtu_pkg::KIND_BITS);
            r_q_odd   <= tx_q[0];
            r_bit_off <= tx_off;
            r_rd_base <= (tx_kind == mbrtu_pkg::KIND_BITS) ? start17 + SW'(tx_off) :
                                                             start17 + SW'(tx_q >> 1);
        end
        if (i_cmd.tbl_rd) begin
            r_rd_ok <= rd_in_range && (!r_is_bits || rd_bit_ok);
        end
        if (i_cmd.fin) begin
            r_out_tx_valid <= r_res_valid;
            r_out_byte     <= r_res_byte;
            r_out_last     <= r_res_last;
            r_out_status   <= r_res_status;
        end
    end

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= 8'd1;
            r_mode       <= mbrtu_pkg::MODE_IDLE;
            r_rcnt       <= '0;
            r_exp        <= '0;
            r_rcrc       <= mbrtu_pkg::CRC_INIT;
            r_resp_len   <= '0;
            r_tx_pos     <= '0;
            r_tx_crc     <= mbrtu_pkg::CRC_INIT;
            r_clr_addr   <= '0;
            r_wi         <= '0;
            r_j          <= '0;
            r_out_valid  <= 1'b0;
            r_res_valid  <= 1'b0;
            r_res_last   <= 1'b0;
            r_res_byte   <= 8'h00;
            r_res_status <= mbrtu_pkg::FST_NONE;
            r_crc_upd    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slave_addr <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.latch) begin
                r_res_valid  <= 1'b0;
                r_res_last   <= 1'b0;
                r_res_byte   <= 8'h00;
                r_res_status <= mbrtu_pkg::FST_NONE;
                r_crc_upd    <= 1'b0;
            end
            if (i_cmd.rx) begin
                if (rx_match) begin
                    r_rcnt <= CW'(1);
                    r_exp  <= '0;
                    r_rcrc <= rx_crc;
                    r_mode <= mbrtu_pkg::MODE_RX;
                end else if (r_mode == mbrtu_pkg::MODE_RX) begin
                    r_res_status <= rx_status;
                    r_wi         <= '0;
                    if (rx_kill || rx_done) begin
                        r_mode <= rx_go ? mbrtu_pkg::MODE_TX : mbrtu_pkg::MODE_IDLE;
                        r_rcrc <= mbrtu_pkg::CRC_INIT;
                        r_rcnt <= '0;
                        r_exp  <= rx_exp;
                    end else begin
                        r_rcnt <= rx_cnt;
                        r_rcrc <= rx_crc;
                        r_exp  <= rx_exp;
                    end
                    if (rx_go) begin
                        r_resp_len <= ex_len[CW-1:0];
                        r_tx_pos   <= '0;
                        r_tx_crc   <= mbrtu_pkg::CRC_INIT;
                    end
                end
            end
            if (i_cmd.walk_wr) begin
                r_wi <= r_wi + mbrtu_pkg::WI_W'(1);
            end
            if (i_cmd.tx_begin) begin
                r_res_valid <= 1'b1;
                r_tx_pos    <= r_tx_pos + CW'(1);
                r_j         <= '0;
                if (tx_data) begin
                    r_crc_upd  <= 1'b1;
                    r_res_byte <= (tx_kind == mbrtu_pkg::KIND_IMM) ? tx_imm : 8'h00;
                end else if (tx_p2 == tx_len2) begin
                    r_res_byte <= r_tx_crc[7:0];
                end else begin
                    r_res_byte <= r_tx_crc[15:8];
                    r_res_last <= 1'b1;
                    r_mode     <= mbrtu_pkg::MODE_IDLE;
                end
            end
            if (i_cmd.tbl_acc) begin
                if (r_is_bits) begin
                    r_res_byte[r_j] <= tbl_bit;
                    r_j             <= r_j + 3'd1;
                end else begin
                    r_res_byte <= r_q_odd ? tbl_reg[7:0] : tbl_reg[15:8];
                end
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
                if (r_crc_upd) begin
                    r_tx_crc <= mbrtu_pkg::crc_add(r_tx_crc, r_res_byte);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_clr_addr == AW'(mbrtu_pkg::TABLE_DEPTH - 1));
        o_sts.out_busy  = r_out_valid;
        o_sts.opcode    = r_op;
        o_sts.mode_tx   = (r_mode == mbrtu_pkg::MODE_TX);
        o_sts.rx_walk   = rx_go && ex_walk;
        o_sts.tx_kind   = tx_kind;
        o_sts.tbl_more  = r_is_bits && (r_j != 3'd7);
        o_sts.walk_fc16 = (r_fc == mbrtu_pkg::FC_WR_REGS);
        o_sts.walk_last = (16'(r_wi) + 16'd1 == r_cnt);
    end

    assign o_out_valid    = r_out_valid;
    assign o_tx_valid     = r_out_tx_valid;
    assign o_tx_byte      = r_out_byte;
    assign o_tx_last      = r_out_last;
    assign o_frame_status = r_out_status;

endmodule

[sv/mbrtu_ctrl.sv]
// ----------------------------------------------------------------------------
// mbrtu_ctrl: sequencing state machine of the frame engine
// Runs the clearing pass, takes one event at a time and steps the datapath
// through receive, table walk, table read and result hand-off.
// ----------------------------------------------------------------------------
module mbrtu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mbrtu_pkg::t_dp_sts i_sts,
    output mbrtu_pkg::t_dp_cmd o_cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_DECODE = 4'd2;
    localparam logic [3:0] ST_RX     = 4'd3;
    localparam logic [3:0] ST_LOCAL  = 4'd4;
    localparam logic [3:0] ST_TXB    = 4'd5;
    localparam logic [3:0] ST_TRD    = 4'd6;
    localparam logic [3:0] ST_TACC   = 4'd7;
    localparam logic [3:0] ST_WRD    = 4'd8;
    localparam logic [3:0] ST_WHI    = 4'd9;
    localparam logic [3:0] ST_WWR    = 4'd10;
    localparam logic [3:0] ST_FIN    = 4'd11;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = !i_sts.out_busy;
                if (i_in_valid && !i_sts.out_busy) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_sts.opcode) inside
                    mbrtu_pkg::OP_RX: n_state = ST_RX;
                    mbrtu_pkg::OP_TX: n_state = i_sts.mode_tx ? ST_TXB : ST_FIN;
                    mbrtu_pkg::OP_SET_INPUT, mbrtu_pkg::OP_SET_DISC,
                    mbrtu_pkg::OP_SET_HOLD, mbrtu_pkg::OP_SET_COIL: n_state = ST_LOCAL;
                    default: n_state = ST_FIN;
                endcase
            end
            ST_RX: begin
                o_cmd.rx = 1'b1;
                n_state  = i_sts.rx_walk ? ST_WRD : ST_FIN;
            end
            ST_LOCAL: begin
                o_cmd.local_wr = 1'b1;
                n_state        = ST_FIN;
            end
            ST_TXB: begin
                o_cmd.tx_begin = 1'b1;
                n_state = (i_sts.tx_kind == mbrtu_pkg::KIND_IMM) ? ST_FIN : ST_TRD;
            end
            ST_TRD: begin
                o_cmd.tbl_rd = 1'b1;
                n_state      = ST_TACC;
            end
            ST_TACC: begin
                o_cmd.tbl_acc = 1'b1;
                n_state       = i_sts.tbl_more ? ST_TRD : ST_FIN;
            end
            ST_WRD: begin
                n_state = i_sts.walk_fc16 ? ST_WHI : ST_WWR;
            end
            ST_WHI: begin
                o_cmd.walk_hi = 1'b1;
                n_state       = ST_WWR;
            end
            ST_WWR: begin
                o_cmd.walk_wr = 1'b1;
                n_state       = i_sts.walk_last ? ST_FIN : ST_WRD;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // no event taken until the tables are cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_in_ready)
        else $error("event accepted during clearing pass");

    // a result hand-off is always followed by idle
    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_state == ST_IDLE))
        else $error("result hand-off not followed by idle");

    // a walk write always follows a buffer read
    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WWR) |-> ($past(r_state) == ST_WRD || $past(r_state) == ST_WHI))
        else $error("walk write without buffer read");

    // a transmit step only runs while a response is pending
    a_read_needs_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TXB) |-> $past(i_sts.mode_tx))
        else $error("transmit step without pending response");

endmodule
